// File: rtl/sle_pkg.sv
// shared types, constants and codes for the sequential list engine
package sle_pkg;

    // list geometry
    localparam int CAPACITY   = 128;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 8;
    localparam int FIDX_W     = 7;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // match reduction grouping
    localparam int GROUP_SIZE  = 16;
    localparam int GLOC_W      = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_CELLS   = NUM_GROUPS * GROUP_SIZE;
    localparam int FULL_IDX_W  = (PAD_CELLS > 1) ? $clog2(PAD_CELLS) : 1;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_GRP,
        S_FIN
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic                     ins_en;
        logic                     ers_en;
        logic [POS_W-1:0]         pos;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] key;
    } cell_ctrl_t;

    // registered result of one group of cells
    typedef struct packed {
        logic                     hit;
        logic [GLOC_W-1:0]        idx;
        logic signed [DATA_W-1:0] val;
    } grp_res_t;

endpackage

// File: rtl/sequential_list_engine.sv
// top level: cell row, group reduction, sequencer and result register
// an accepted word goes through the group stage, then the finish stage that commits its result
//   word; no new word is taken until that commit, since the registered match reduction over the
//   cell groups is followed by the commit that shifts the cell row
// a stalled result holds the commit cycle until the output register frees up
// reset clears the entry count, sequencer and output valid; cell contents are
//   undefined until written and are never read before that
module sequential_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [sle_pkg::POS_W-1:0]         position,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [sle_pkg::DATA_W-1:0] removed_value,
    output logic                              found,
    output logic [sle_pkg::FIDX_W-1:0]        found_index,
    output logic [sle_pkg::CNT_W-1:0]         entry_count
);
    import sle_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    logic [1:0]               op_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;
    logic                     found_reg;
    logic                     found_next;
    logic [FIDX_W-1:0]        fidx_reg;
    logic [FIDX_W-1:0]        fidx_next;

    logic                     accept;
    logic                     out_free;
    logic                     commit;
    logic                     ins_ok;
    logic                     ers_ok;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [PAD_CELLS-1:0]     hit_all;
    logic [PAD_CELLS-1:0][DATA_W-1:0] sel_all;
    grp_res_t                 grp_res [NUM_GROUPS];

    logic                     fin_hit;
    logic [FULL_IDX_W-1:0]    fin_idx;
    logic signed [DATA_W-1:0] fin_val;

    // handshake
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_FIN) && out_free;

    // broadcast control
    assign ctrl.ins_en = commit && ins_ok;
    assign ctrl.ers_en = commit && ers_ok;
    assign ctrl.pos    = pos_reg;
    assign ctrl.count  = count_reg;
    assign ctrl.key    = key_reg;

    // cell row
    genvar k;
    generate
        for (k = 0; k < PAD_CELLS; k++)
        begin : g_cell
            if (k < CAPACITY)
            begin : g_real
                logic signed [DATA_W-1:0] left_d;
                logic signed [DATA_W-1:0] right_d;
                logic signed [DATA_W-1:0] sel_d;
                if (k == 0)
                begin : g_first
                    assign left_d = key_reg;
                end
                else
                begin : g_mid_l
                    assign left_d = cell_data[k-1];
                end
                if (k == CAPACITY - 1)
                begin : g_last
                    assign right_d = '0;
                end
                else
                begin : g_mid_r
                    assign right_d = cell_data[k+1];
                end
                sle_cell u_cell (
                    .clk        (clk),
                    .cell_idx   (IDX_W'(k)),
                    .ctrl       (ctrl),
                    .left_data  (left_d),
                    .right_data (right_d),
                    .data       (cell_data[k]),
                    .hit        (hit_all[k]),
                    .sel_val    (sel_d)
                );
                assign sel_all[k] = sel_d;
            end
            else
            begin : g_pad
                assign hit_all[k] = 1'b0;
                assign sel_all[k] = '0;
            end
        end
    endgenerate

    // group reduction, captured in the group stage
    genvar g;
    generate
        for (g = 0; g < NUM_GROUPS; g++)
        begin : g_grp
            sle_group u_group (
                .clk     (clk),
                .capture (state_reg == S_GRP),
                .hit_vec (hit_all[g*GROUP_SIZE +: GROUP_SIZE]),
                .val_vec (sel_all[g*GROUP_SIZE +: GROUP_SIZE]),
                .res     (grp_res[g])
            );
        end
    endgenerate

    // final merge across groups, lowest group wins
    always_comb
    begin
        fin_hit = 1'b0;
        fin_idx = '0;
        fin_val = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--)
        begin
            if (grp_res[i].hit)
            begin
                fin_hit = 1'b1;
                fin_idx = FULL_IDX_W'(i * GROUP_SIZE) + FULL_IDX_W'(grp_res[i].idx);
            end
            fin_val = fin_val | grp_res[i].val;
        end
    end

    // operation decode and result
    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb
    begin
        ins_ok       = 1'b0;
        ers_ok       = 1'b0;
        status_next  = ST_OK;
        removed_next = '0;
        found_next   = 1'b0;
        fidx_next    = '0;
        count_next   = count_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    status_next = ST_RANGE;
                else if (count_reg == CNT_W'(CAPACITY))
                    status_next = ST_FULL;
                else
                begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_ERASE:
            begin
                if (pos_ext >= cnt_ext)
                    status_next = ST_RANGE;
                else
                begin
                    ers_ok       = 1'b1;
                    removed_next = fin_val;
                    count_next   = count_reg - 1'b1;
                end
            end
            OP_FIND:
            begin
                found_next = fin_hit;
                fidx_next  = fin_hit ? FIDX_W'(fin_idx) : '0;
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_GRP;
            end
            S_GRP:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input word and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            key_reg <= value;
        end
        if (commit)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            found_reg   <= found_next;
            fidx_reg    <= fidx_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign found         = found_reg;
    assign found_index   = fidx_reg;
    assign entry_count   = count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 (state_reg == S_FIN))
        else $error("sequencer not in finish stage two cycles after accepted word");

    a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("entry count changed outside commit");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (status_reg == ST_OK))
        else $error("found flagged with error status");

    a_index_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (fidx_reg == '0))
        else $error("nonzero index on a miss");

endmodule

// File: rtl/sle_cell.sv
// one list cell: holds an entry, shifts with its neighbors, compares locally
module sle_cell (
    input  logic                             clk,
    input  logic [sle_pkg::IDX_W-1:0]        cell_idx,
    input  sle_pkg::cell_ctrl_t              ctrl,
    input  logic signed [sle_pkg::DATA_W-1:0] left_data,
    input  logic signed [sle_pkg::DATA_W-1:0] right_data,
    output logic signed [sle_pkg::DATA_W-1:0] data,
    output logic                             hit,
    output logic signed [sle_pkg::DATA_W-1:0] sel_val
);
    import sle_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [CMP_W-1:0]         idx_ext;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;

    assign idx_ext = CMP_W'(cell_idx);
    assign pos_ext = CMP_W'(ctrl.pos);
    assign cnt_ext = CMP_W'(ctrl.count);

    // local compare against the key, only for live entries
    assign hit     = (data_reg == ctrl.key) && (idx_ext < cnt_ext);
    assign sel_val = (idx_ext == pos_ext) ? data_reg : '0;
    assign data    = data_reg;

    // shift up on insert, down on erase
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (idx_ext > pos_ext)
                data_next = left_data;
            else if (idx_ext == pos_ext)
                data_next = ctrl.key;
        end
        else if (ctrl.ers_en)
        begin
            if (idx_ext >= pos_ext)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: rtl/sle_group.sv
// registered priority match and value merge over one group of cells
module sle_group (
    input  logic                                            clk,
    input  logic                                            capture,
    input  logic [sle_pkg::GROUP_SIZE-1:0]                  hit_vec,
    input  logic [sle_pkg::GROUP_SIZE-1:0][sle_pkg::DATA_W-1:0] val_vec,
    output sle_pkg::grp_res_t                               res
);
    import sle_pkg::*;

    grp_res_t res_reg;
    grp_res_t res_next;

    // lowest hit wins, selected values are one-hot so they merge by or
    always_comb
    begin
        res_next = '0;
        for (int j = GROUP_SIZE - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                res_next.hit = 1'b1;
                res_next.idx = GLOC_W'(j);
            end
            res_next.val = res_next.val | val_vec[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
